>>> src/abf_pkg.sv
// ----------------------------------------------------------------------------
// abf_pkg
// Shared types and codes of the arena best-fit allocator.
// ----------------------------------------------------------------------------
package abf_pkg;

  localparam int unsigned AddrW = 32;
  localparam int unsigned LenW  = 32;
  localparam int unsigned AlgW  = 5;
  localparam int unsigned ModeW = 2;
  localparam int unsigned StatW = 3;

  // operation codes
  localparam logic [ModeW-1:0] ModeAlloc = 2'd0;
  localparam logic [ModeW-1:0] ModePlace = 2'd1;
  localparam logic [ModeW-1:0] ModeClear = 2'd2;

  // status codes
  localparam logic [StatW-1:0] StOk      = 3'd0;
  localparam logic [StatW-1:0] StFull    = 3'd1;
  localparam logic [StatW-1:0] StOutside = 3'd2;
  localparam logic [StatW-1:0] StOverlap = 3'd3;
  localparam logic [StatW-1:0] StNoFit   = 3'd4;

  // configuration register indexes
  localparam logic CfgWinStart = 1'b0;
  localparam logic CfgWinEnd   = 1'b1;

  // one table entry: half-open block [start, stop)
  typedef struct packed {
    logic [AddrW-1:0] start;
    logic [AddrW-1:0] stop;
  } entry_t;

  // one request
  typedef struct packed {
    logic [AlgW-1:0]  align_log2;
    logic [LenW-1:0]  length_bytes;
    logic [AddrW-1:0] place_address;
    logic [ModeW-1:0] mode;
  } req_t;

  // one result
  typedef struct packed {
    logic [AddrW-1:0] granted_address;
    logic [StatW-1:0] status;
  } res_t;

endpackage

>>> src/arena_best_fit_allocator.sv
// Clear, full and out-of-window answers skip the table walk; place reads the
// table entry of each of the n recorded blocks in turn to check for overlap.
// Allocate walks up to n+1 gaps, each with up to n+1 covering passes over the
// table plus one gap-end scan.
// One request in flight; a new request is taken while a result waits in out_q.
// Reset empties the table and clears the window registers to zero.
// ----------------------------------------------------------------------------
// arena_best_fit_allocator
// Push-only arena allocator with best-fit gap search over a configured window.
// ----------------------------------------------------------------------------
module arena_best_fit_allocator #(
  parameter int unsigned MAX_BLOCKS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  // requests
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // mode[1:0], place_address[33:2], length_bytes[65:34], align_log2[70:66]
  input  logic [71:0] s_axis_tdata,
  // results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[2:0], granted_address[34:3]
  output logic [39:0] m_axis_tdata
);

  localparam int unsigned IdxW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CntW = $clog2(MAX_BLOCKS + 1);

  logic [abf_pkg::AddrW-1:0] win_start_q, win_end_q;
  logic                      out_valid_q;
  abf_pkg::res_t             out_q;
  logic                      idle;
  logic                      res_valid;
  logic                      res_load;
  abf_pkg::res_t             res;
  abf_pkg::req_t             req;
  logic                      tbl_we;
  logic [IdxW-1:0]           tbl_waddr, tbl_raddr;
  abf_pkg::entry_t           tbl_wdata, tbl_rdata;

  assign req           = abf_pkg::req_t'(s_axis_tdata[70:0]);
  assign s_axis_tready = idle;
  assign res_load      = res_valid && (!out_valid_q || m_axis_tready);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_q};

  // window registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_start_q <= '0;
      win_end_q   <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == abf_pkg::CfgWinStart) begin
        win_start_q <= cfg_wdata_i;
      end else begin
        win_end_q <= cfg_wdata_i;
      end
    end
  end

  // output register: hold a result until its transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_q <= res;
    end
  end

  abf_seq #(
    .MaxBlocks (MAX_BLOCKS),
    .IdxW      (IdxW),
    .CntW      (CntW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .win_start_i (win_start_q),
    .win_end_i   (win_end_q),
    .start_i     (s_axis_tvalid && idle),
    .req_i       (req),
    .idle_o      (idle),
    .res_valid_o (res_valid),
    .res_ready_i (res_load),
    .res_o       (res),
    .tbl_we_o    (tbl_we),
    .tbl_waddr_o (tbl_waddr),
    .tbl_wdata_o (tbl_wdata),
    .tbl_raddr_o (tbl_raddr),
    .tbl_rdata_i (tbl_rdata)
  );

  abf_table #(
    .Depth (MAX_BLOCKS),
    .IdxW  (IdxW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

endmodule

>>> src/abf_table.sv
// ----------------------------------------------------------------------------
// abf_table
// Block table memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module abf_table #(
  parameter int unsigned Depth = 16,
  parameter int unsigned IdxW  = 4
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [IdxW-1:0]     waddr_i,
  input  abf_pkg::entry_t     wdata_i,
  input  logic [IdxW-1:0]     raddr_i,
  output abf_pkg::entry_t     rdata_o
);

  abf_pkg::entry_t mem_q [Depth];
  abf_pkg::entry_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered data
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/abf_seq.sv
// ----------------------------------------------------------------------------
// abf_seq
// Request sequencer: walks the block table for place checks and best-fit gap
// search, then records the new block.
// ----------------------------------------------------------------------------
module abf_seq #(
  parameter int unsigned MaxBlocks = 16,
  parameter int unsigned IdxW      = 4,
  parameter int unsigned CntW      = 5
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [abf_pkg::AddrW-1:0]   win_start_i,
  input  logic [abf_pkg::AddrW-1:0]   win_end_i,
  input  logic                        start_i,
  input  abf_pkg::req_t               req_i,
  output logic                        idle_o,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output abf_pkg::res_t               res_o,
  output logic                        tbl_we_o,
  output logic [IdxW-1:0]             tbl_waddr_o,
  output abf_pkg::entry_t             tbl_wdata_o,
  output logic [IdxW-1:0]             tbl_raddr_o,
  input  abf_pkg::entry_t             tbl_rdata_i
);

  localparam int unsigned WideW = abf_pkg::AddrW + 1;

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SDisp  = 4'd1;
  localparam logic [3:0] SPRd   = 4'd2;
  localparam logic [3:0] SPEv   = 4'd3;
  localparam logic [3:0] SGap   = 4'd4;
  localparam logic [3:0] SPass  = 4'd5;
  localparam logic [3:0] SCRd   = 4'd6;
  localparam logic [3:0] SCEv   = 4'd7;
  localparam logic [3:0] SChk   = 4'd8;
  localparam logic [3:0] SERd   = 4'd9;
  localparam logic [3:0] SEEv   = 4'd10;
  localparam logic [3:0] SGEnd  = 4'd11;
  localparam logic [3:0] SFin   = 4'd12;
  localparam logic [3:0] SDone  = 4'd13;

  logic [3:0]              state_q, state_d;
  abf_pkg::req_t           req_q, req_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic [CntW-1:0]         idx_q, idx_d;
  logic [CntW-1:0]         gap_q, gap_d;
  logic [CntW-1:0]         pass_q, pass_d;
  logic [WideW-1:0]        cur_q, cur_d;
  logic [WideW-1:0]        s_q, s_d;
  logic [WideW-1:0]        e_q, e_d;
  logic [WideW-1:0]        best_size_q, best_size_d;
  logic [abf_pkg::AddrW-1:0] best_s_q, best_s_d;
  logic                    found_q, found_d;
  abf_pkg::res_t           res_q, res_d;

  logic [WideW-1:0]        wend;
  logic [WideW-1:0]        place_end;
  logic [WideW-1:0]        rd_bs, rd_be;
  logic [WideW-1:0]        gap_size;
  logic [WideW-1:0]        align_mask;
  logic [WideW-1:0]        align_in;
  logic [WideW-1:0]        aligned;

  assign wend      = {1'b0, win_end_i};
  assign place_end = {1'b0, req_q.place_address} + {1'b0, req_q.length_bytes};
  assign rd_bs     = {1'b0, tbl_rdata_i.start};
  assign rd_be     = {1'b0, tbl_rdata_i.stop};
  assign gap_size  = e_q - s_q;

  // align up: shared by the gap start and the skip past a covering block
  assign align_mask = (WideW'(1) << req_q.align_log2) - WideW'(1);
  assign align_in   = (state_q == SCEv) ? rd_be : cur_q;
  assign aligned    = (align_in + align_mask) & ~align_mask;

  assign tbl_raddr_o = idx_q[IdxW-1:0];
  assign tbl_waddr_o = cnt_q[IdxW-1:0];
  assign idle_o      = (state_q == SIdle);
  assign res_valid_o = (state_q == SDone);
  assign res_o       = res_q;

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    gap_d       = gap_q;
    pass_d      = pass_q;
    cur_d       = cur_q;
    s_d         = s_q;
    e_d         = e_q;
    best_size_d = best_size_q;
    best_s_d    = best_s_q;
    found_d     = found_q;
    res_d       = res_q;
    tbl_we_o    = 1'b0;
    tbl_wdata_o = '{start: req_q.place_address, stop: place_end[abf_pkg::AddrW-1:0]};

    case (state_q)
      SIdle: begin
        if (start_i) begin
          req_d   = req_i;
          state_d = SDisp;
        end
      end
      // pick the operation
      SDisp: begin
        res_d   = '{granted_address: '0, status: abf_pkg::StOk};
        idx_d   = '0;
        state_d = SDone;
        if (req_q.mode == abf_pkg::ModeClear) begin
          cnt_d = '0;
        end else if (req_q.mode == abf_pkg::ModePlace ||
                     req_q.mode == abf_pkg::ModeAlloc) begin
          if (cnt_q >= CntW'(MaxBlocks)) begin
            res_d.status = abf_pkg::StFull;
          end else if (req_q.mode == abf_pkg::ModePlace) begin
            if (req_q.place_address < win_start_i || place_end > wend) begin
              res_d.status = abf_pkg::StOutside;
            end else begin
              state_d = SPRd;
            end
          end else begin
            cur_d   = {1'b0, win_start_i};
            gap_d   = '0;
            found_d = 1'b0;
            state_d = SGap;
          end
        end
      end
      // place: scan for conflicts, record when clean
      SPRd: begin
        if (idx_q == cnt_q) begin
          tbl_we_o  = 1'b1;
          cnt_d     = cnt_q + CntW'(1);
          res_d.granted_address = req_q.place_address;
          state_d   = SDone;
        end else begin
          state_d = SPEv;
        end
      end
      SPEv: begin
        if (({1'b0, req_q.place_address} < rd_bs && rd_bs < place_end) ||
            ({1'b0, req_q.place_address} >= rd_bs &&
             {1'b0, req_q.place_address} < rd_be)) begin
          res_d.status = abf_pkg::StOverlap;
          state_d      = SDone;
        end else begin
          idx_d   = idx_q + CntW'(1);
          state_d = SPRd;
        end
      end
      // alloc: start a gap at the aligned cursor
      SGap: begin
        s_d     = aligned;
        pass_d  = '0;
        state_d = SPass;
      end
      SPass: begin
        idx_d   = '0;
        state_d = (s_q >= wend) ? SFin : SCRd;
      end
      // look for a block covering the gap start
      SCRd: begin
        if (idx_q == cnt_q) begin
          idx_d   = '0;
          e_d     = wend;
          state_d = SERd;
        end else begin
          state_d = SCEv;
        end
      end
      SCEv: begin
        if (s_q >= rd_bs && s_q < rd_be) begin
          s_d = aligned;
          if (pass_q == cnt_q) begin
            state_d = SChk;
          end else begin
            pass_d  = pass_q + CntW'(1);
            state_d = SPass;
          end
        end else begin
          idx_d   = idx_q + CntW'(1);
          state_d = SCRd;
        end
      end
      SChk: begin
        idx_d   = '0;
        e_d     = wend;
        state_d = (s_q >= wend) ? SFin : SERd;
      end
      // find the lowest block start above the gap start
      SERd: begin
        state_d = (idx_q == cnt_q) ? SGEnd : SEEv;
      end
      SEEv: begin
        if (rd_bs > s_q && rd_bs < e_q) begin
          e_d = rd_bs;
        end
        idx_d   = idx_q + CntW'(1);
        state_d = SERd;
      end
      // score the gap, advance the cursor
      SGEnd: begin
        if (gap_size >= {1'b0, req_q.length_bytes} &&
            (!found_q || gap_size < best_size_q)) begin
          found_d     = 1'b1;
          best_s_d    = s_q[abf_pkg::AddrW-1:0];
          best_size_d = gap_size;
        end
        cur_d = e_q;
        if (e_q >= wend || gap_q == cnt_q) begin
          state_d = SFin;
        end else begin
          gap_d   = gap_q + CntW'(1);
          state_d = SGap;
        end
      end
      SFin: begin
        state_d = SDone;
        if (!found_q) begin
          res_d.status = abf_pkg::StNoFit;
        end else begin
          tbl_we_o    = 1'b1;
          tbl_wdata_o = '{start: best_s_q, stop: best_s_q + req_q.length_bytes};
          cnt_d       = cnt_q + CntW'(1);
          res_d.granted_address = best_s_q;
        end
      end
      SDone: begin
        if (res_ready_i) begin
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    idx_q       <= idx_d;
    gap_q       <= gap_d;
    pass_q      <= pass_d;
    cur_q       <= cur_d;
    s_q         <= s_d;
    e_q         <= e_d;
    best_size_q <= best_size_d;
    best_s_q    <= best_s_d;
    found_q     <= found_d;
    res_q       <= res_d;
  end

endmodule
